[hdl/cpg_pkg.sv]
// Package for the circle point generator: widths, operation and move codes,
// the request and response word types and the quadrant move table.
// Depends on nothing; every other file of the block refers to it by scoped names.
package cpg_pkg;

   // Field widths of the words on both channels.
   localparam int COORD_WIDTH  = 16;
   localparam int RADIUS_WIDTH = 13;

   // The horizontal and vertical terms reach a little over twice the radius,
   // and the error term a few times the radius, each with a sign bit.
   localparam int TERM_WIDTH  = RADIUS_WIDTH + 3;
   localparam int ERROR_WIDTH = RADIUS_WIDTH + 7;

   // The circle is finished when the vertical term runs out in this quadrant.
   localparam logic [1:0] LAST_QUADRANT = 2'd3;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      MOVE_HORIZ = 2'd0,
      MOVE_DIAG  = 2'd1,
      MOVE_VERT  = 2'd2
   } move_type;

   typedef struct packed {
      op_type                          operation;
      logic signed [COORD_WIDTH-1:0]   center_x;
      logic signed [COORD_WIDTH-1:0]   center_y;
      logic        [RADIUS_WIDTH-1:0]  radius;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic                          pen_down;
      logic                          last_point;
      logic                          point_valid;
   } rsp_type;

   typedef struct packed {
      logic signed [1:0] dx;
      logic signed [1:0] dy;
   } delta_type;

   // Pen movement for one move, turned through the current quadrant.
   function automatic delta_type move_delta(input logic [1:0] quad, input move_type mv);
      delta_type d;
      d = '{dx: 2'sd0, dy: 2'sd0};
      case (quad)
         2'd0: begin
            case (mv)
               MOVE_HORIZ: d = '{dx:  2'sd0, dy:  2'sd1};
               MOVE_DIAG:  d = '{dx:  2'sd1, dy:  2'sd1};
               MOVE_VERT:  d = '{dx:  2'sd1, dy:  2'sd0};
               default:    d = '{dx:  2'sd0, dy:  2'sd0};
            endcase
         end
         2'd1: begin
            case (mv)
               MOVE_HORIZ: d = '{dx:  2'sd1, dy:  2'sd0};
               MOVE_DIAG:  d = '{dx:  2'sd1, dy: -2'sd1};
               MOVE_VERT:  d = '{dx:  2'sd0, dy: -2'sd1};
               default:    d = '{dx:  2'sd0, dy:  2'sd0};
            endcase
         end
         2'd2: begin
            case (mv)
               MOVE_HORIZ: d = '{dx:  2'sd0, dy: -2'sd1};
               MOVE_DIAG:  d = '{dx: -2'sd1, dy: -2'sd1};
               MOVE_VERT:  d = '{dx: -2'sd1, dy:  2'sd0};
               default:    d = '{dx:  2'sd0, dy:  2'sd0};
            endcase
         end
         default: begin
            case (mv)
               MOVE_HORIZ: d = '{dx: -2'sd1, dy:  2'sd0};
               MOVE_DIAG:  d = '{dx: -2'sd1, dy:  2'sd1};
               MOVE_VERT:  d = '{dx:  2'sd0, dy:  2'sd1};
               default:    d = '{dx:  2'sd0, dy:  2'sd0};
            endcase
         end
      endcase
      return d;
   endfunction

endpackage

[hdl/cpg_engine.sv]
// Circle stepping engine: holds the pen, quadrant and error terms and works
// out the point for one request word in a single pass. Uses cpg_pkg.
// Instantiated by circle_point_generator.
module cpg_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  cpg_pkg::req_type req_word,
   output cpg_pkg::rsp_type result
);

   localparam int TEST_WIDTH = cpg_pkg::ERROR_WIDTH + 2;

   logic signed [cpg_pkg::COORD_WIDTH-1:0]  pen_x_ff, pen_x_in;
   logic signed [cpg_pkg::COORD_WIDTH-1:0]  pen_y_ff, pen_y_in;
   logic        [1:0]                       quadrant_ff, quadrant_in;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   horiz_ff, horiz_in;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   vert_ff, vert_in;
   logic signed [cpg_pkg::ERROR_WIDTH-1:0]  error_ff, error_in;
   logic        [cpg_pkg::RADIUS_WIDTH-1:0] radius_ff, radius_in;
   logic                                    active_ff, active_in;

   logic signed [cpg_pkg::TERM_WIDTH-1:0]   start_vert;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   turn_vert;
   logic signed [cpg_pkg::ERROR_WIDTH:0]    twice_err;
   logic signed [TEST_WIDTH-1:0]            test_horiz;
   logic signed [TEST_WIDTH-1:0]            test_vert;
   cpg_pkg::move_type                       move;
   cpg_pkg::delta_type                      delta;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   horiz_step;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   vert_step;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   horiz_moved;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   vert_moved;
   logic signed [cpg_pkg::ERROR_WIDTH-1:0]  error_moved;
   logic signed [cpg_pkg::COORD_WIDTH-1:0]  step_x;
   logic signed [cpg_pkg::COORD_WIDTH-1:0]  step_y;

   // Fresh vertical term, twice the radius less one, for a new circle and a new quadrant.
   assign start_vert = $signed({2'b00, req_word.radius, 1'b0}) - cpg_pkg::TERM_WIDTH'(1);
   assign turn_vert  = $signed({2'b00, radius_ff, 1'b0}) - cpg_pkg::TERM_WIDTH'(1);

   // Move choice from sign tests on the doubled error term.
   assign twice_err  = $signed({error_ff, 1'b0});
   assign test_horiz = TEST_WIDTH'(twice_err) + TEST_WIDTH'(horiz_ff);
   assign test_vert  = TEST_WIDTH'(twice_err) - TEST_WIDTH'(vert_ff);

   always_comb begin
      if (twice_err < 0) begin
         move = (test_horiz < 0) ? cpg_pkg::MOVE_VERT : cpg_pkg::MOVE_DIAG;
      end else begin
         move = (test_vert >= 0) ? cpg_pkg::MOVE_HORIZ : cpg_pkg::MOVE_DIAG;
      end
   end

   assign horiz_step = horiz_ff + cpg_pkg::TERM_WIDTH'(2);
   assign vert_step  = vert_ff - cpg_pkg::TERM_WIDTH'(2);

   // Term updates for the chosen move.
   always_comb begin
      case (move)
         cpg_pkg::MOVE_VERT: begin
            horiz_moved = horiz_ff;
            vert_moved  = vert_step;
            error_moved = error_ff + cpg_pkg::ERROR_WIDTH'(vert_step);
         end
         cpg_pkg::MOVE_HORIZ: begin
            horiz_moved = horiz_step;
            vert_moved  = vert_ff;
            error_moved = error_ff - cpg_pkg::ERROR_WIDTH'(horiz_step);
         end
         default: begin
            horiz_moved = horiz_step;
            vert_moved  = vert_step;
            error_moved = error_ff + cpg_pkg::ERROR_WIDTH'(vert_step)
                          - cpg_pkg::ERROR_WIDTH'(horiz_step);
         end
      endcase
   end

   // Pen position after the move, wrapping at the coordinate width.
   assign delta  = cpg_pkg::move_delta(quadrant_ff, move);
   assign step_x = pen_x_ff + cpg_pkg::COORD_WIDTH'(delta.dx);
   assign step_y = pen_y_ff + cpg_pkg::COORD_WIDTH'(delta.dy);

   // Next state and the response word for the item at the input.
   always_comb begin
      pen_x_in    = pen_x_ff;
      pen_y_in    = pen_y_ff;
      quadrant_in = quadrant_ff;
      horiz_in    = horiz_ff;
      vert_in     = vert_ff;
      error_in    = error_ff;
      radius_in   = radius_ff;
      active_in   = active_ff;
      result      = '0;

      if (req_word.operation == cpg_pkg::OP_START) begin
         radius_in   = req_word.radius;
         pen_x_in    = req_word.center_x - cpg_pkg::COORD_WIDTH'(req_word.radius);
         pen_y_in    = req_word.center_y;
         quadrant_in = 2'd0;
         horiz_in    = cpg_pkg::TERM_WIDTH'(1);
         vert_in     = start_vert;
         error_in    = cpg_pkg::ERROR_WIDTH'(start_vert) - cpg_pkg::ERROR_WIDTH'(1);
         active_in   = (req_word.radius != '0);
         result.point_x     = pen_x_in;
         result.point_y     = pen_y_in;
         result.pen_down    = 1'b0;
         result.last_point  = (req_word.radius == '0);
         result.point_valid = 1'b1;
      end else if (active_ff) begin
         pen_x_in = step_x;
         pen_y_in = step_y;
         horiz_in = horiz_moved;
         vert_in  = vert_moved;
         error_in = error_moved;
         result.point_x     = step_x;
         result.point_y     = step_y;
         result.pen_down    = 1'b1;
         result.point_valid = 1'b1;
         // Vertical term spent: next quadrant, or the circle is closed.
         if (vert_moved < 0) begin
            if (quadrant_ff == cpg_pkg::LAST_QUADRANT) begin
               active_in         = 1'b0;
               result.last_point = 1'b1;
            end else begin
               quadrant_in = quadrant_ff + 2'd1;
               horiz_in    = cpg_pkg::TERM_WIDTH'(1);
               vert_in     = turn_vert;
               error_in    = cpg_pkg::ERROR_WIDTH'(turn_vert) - cpg_pkg::ERROR_WIDTH'(1);
            end
         end
      end
   end

   // State registers, updated only when a word is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff    <= '0;
         pen_y_ff    <= '0;
         quadrant_ff <= 2'd0;
         horiz_ff    <= cpg_pkg::TERM_WIDTH'(1);
         vert_ff     <= -cpg_pkg::TERM_WIDTH'(1);
         error_ff    <= '0;
         radius_ff   <= '0;
         active_ff   <= 1'b0;
      end else if (accept) begin
         pen_x_ff    <= pen_x_in;
         pen_y_ff    <= pen_y_in;
         quadrant_ff <= quadrant_in;
         horiz_ff    <= horiz_in;
         vert_ff     <= vert_in;
         error_ff    <= error_in;
         radius_ff   <= radius_in;
         active_ff   <= active_in;
      end
   end

endmodule

[hdl/circle_point_generator.sv]
// Top level of the circle point generator: the stepping engine followed by
// a two-word output buffer. Uses cpg_pkg and cpg_engine.
//
//   channel  ports                           direction  word
//   request  req_valid, req_stall, req_word  in         cpg_pkg::req_type
//   response rsp_valid, rsp_stall, rsp_word  out        cpg_pkg::rsp_type
//
// Every request word gives one response word, held in the output or skid register.
// A new word can be taken in every cycle while req_stall is low; the engine state updates in
// the same cycle as the word is taken.
// A stalled response is held; a second word goes to the skid register, and
// req_stall rises only while both registers are full.
// Synchronous reset empties the buffer and leaves the generator idle.
module circle_point_generator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cpg_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cpg_pkg::rsp_type rsp_word
);

   logic             req_take;
   logic             rsp_take;
   cpg_pkg::rsp_type engine_word;

   cpg_pkg::rsp_type out_word_ff;
   logic             out_valid_ff;
   cpg_pkg::rsp_type skid_word_ff;
   logic             skid_valid_ff;

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   cpg_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_take),
      .req_word (req_word),
      .result   (engine_word)
   );

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            out_word_ff   <= skid_word_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_word_ff  <= engine_word;
            out_valid_ff <= 1'b1;
         end else begin
            skid_word_ff  <= engine_word;
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

endmodule

[hdl/cpg_checker.sv]
// Port checker for the circle point generator, bound to the top level.
// Uses cpg_pkg for the word types.
module cpg_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cpg_pkg::rsp_type rsp_word
);

   // A stalled response word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // Nothing comes out straight after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A response word only appears for a request word that was taken.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("response word appeared with no request taken");

   // A step with no circle running gives an all-zero word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.point_valid |->
         rsp_word.point_x == '0 && rsp_word.point_y == '0 &&
         !rsp_word.pen_down && !rsp_word.last_point)
      else $error("invalid point carries data");

   // A drawn point always belongs to a running circle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.pen_down |-> rsp_word.point_valid)
      else $error("pen-down point marked invalid");

endmodule

bind circle_point_generator cpg_checker u_cpg_checker (.*);

[dv/circle_point_generator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for circle_point_generator: sends start and step words, traces
// each circle with its own copy of the stepping engine and checks every response word.
// Depends on cpg_pkg and the block's RTL; it reads no files.
module circle_point_generator_tb;

   localparam int RESET_CYCLES = 9;
   localparam int RANDOM_WORDS = 400;
   localparam int FLAT_OUT_WORDS = 100;
   localparam int LONG_HOLD = 160;
   localparam int DRAIN_CYCLES = 20;
   localparam int SMALL_RADIUS = 8;
   localparam int MAX_RADIUS = (1 << cpg_pkg::RADIUS_WIDTH) - 1;
   localparam int MIN_COORD = -(1 << (cpg_pkg::COORD_WIDTH - 1));
   localparam int MAX_COORD = (1 << (cpg_pkg::COORD_WIDTH - 1)) - 1;
   localparam int NO_LIMIT = 1_000_000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cpg_pkg::req_type req_word = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cpg_pkg::rsp_type rsp_word;

   // Tracer state: the pen, the quadrant and the three Bresenham terms.
   logic signed [cpg_pkg::COORD_WIDTH-1:0]  pen_x, pen_y;
   logic        [1:0]                       quad;
   logic signed [cpg_pkg::TERM_WIDTH-1:0]   h_term, v_term;
   logic signed [cpg_pkg::ERROR_WIDTH-1:0]  e_term;
   logic        [cpg_pkg::RADIUS_WIDTH-1:0] circle_radius;
   logic                                    drawing;

   cpg_pkg::rsp_type expected_points[$];
   int      fail_count = 0;
   int      points_checked = 0;
   int      words_sent = 0;
   int      starts_sent = 0;
   int      circles_done = 0;
   int      stall_left = 0;
   logic    idle_on = 1'b1;
   logic    hold_rsp = 1'b0;

   circle_point_generator dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #4 clock = ~clock;

   // Every quadrant begins with the terms of a fresh arc.
   function automatic void fresh_terms();
      h_term = 1;
      v_term = cpg_pkg::TERM_WIDTH'(2 * int'(circle_radius) - 1);
      e_term = cpg_pkg::ERROR_WIDTH'(int'(v_term) - 1);
   endfunction

   // Works out the point that one accepted request word produces and moves the tracer on.
   function automatic cpg_pkg::rsp_type trace_point(input cpg_pkg::req_type w);
      cpg_pkg::rsp_type  p;
      cpg_pkg::move_type mv;
      int                h, v, e, twice, dx, dy;
      p = '0;
      if (w.operation == cpg_pkg::OP_START) begin
         circle_radius = w.radius;
         pen_x = w.center_x
                 - {{(cpg_pkg::COORD_WIDTH - cpg_pkg::RADIUS_WIDTH){1'b0}}, w.radius};
         pen_y = w.center_y;
         quad = '0;
         fresh_terms();
         drawing = (w.radius != '0);
         p.point_x = pen_x;
         p.point_y = pen_y;
         p.last_point = !drawing;
         p.point_valid = 1'b1;
         return p;
      end
      // A step with no circle running gives an empty, invalid point.
      if (!drawing)
         return p;

      h = h_term;
      v = v_term;
      e = e_term;
      twice = e + e;
      if (twice < 0)
         mv = (twice + h < 0) ? cpg_pkg::MOVE_VERT : cpg_pkg::MOVE_DIAG;
      else
         mv = (twice - v >= 0) ? cpg_pkg::MOVE_HORIZ : cpg_pkg::MOVE_DIAG;

      case (mv)
         cpg_pkg::MOVE_VERT: begin
            v = v - 2;
            e = e + v;
         end
         cpg_pkg::MOVE_HORIZ: begin
            h = h + 2;
            e = e - h;
         end
         default: begin
            h = h + 2;
            v = v - 2;
            e = e + v - h;
         end
      endcase
      h_term = cpg_pkg::TERM_WIDTH'(h);
      v_term = cpg_pkg::TERM_WIDTH'(v);
      e_term = cpg_pkg::ERROR_WIDTH'(e);

      // The move is turned through the current quadrant.
      case (quad)
         2'd0: begin
            dx = (mv == cpg_pkg::MOVE_HORIZ) ? 0 : 1;
            dy = (mv == cpg_pkg::MOVE_VERT) ? 0 : 1;
         end
         2'd1: begin
            dx = (mv == cpg_pkg::MOVE_VERT) ? 0 : 1;
            dy = (mv == cpg_pkg::MOVE_HORIZ) ? 0 : -1;
         end
         2'd2: begin
            dx = (mv == cpg_pkg::MOVE_HORIZ) ? 0 : -1;
            dy = (mv == cpg_pkg::MOVE_VERT) ? 0 : -1;
         end
         default: begin
            dx = (mv == cpg_pkg::MOVE_VERT) ? 0 : -1;
            dy = (mv == cpg_pkg::MOVE_HORIZ) ? 0 : 1;
         end
      endcase
      pen_x = pen_x + cpg_pkg::COORD_WIDTH'(dx);
      pen_y = pen_y + cpg_pkg::COORD_WIDTH'(dy);

      // Running out of vertical term closes the quadrant, or the circle in the last one.
      if (v < 0) begin
         if (quad == cpg_pkg::LAST_QUADRANT) begin
            p.last_point = 1'b1;
            drawing = 1'b0;
         end else begin
            quad = quad + 2'd1;
            fresh_terms();
         end
      end
      p.point_x = pen_x;
      p.point_y = pen_y;
      p.pen_down = 1'b1;
      p.point_valid = 1'b1;
      return p;
   endfunction

   function automatic cpg_pkg::req_type start_word(input int cx, input int cy, input int r);
      cpg_pkg::req_type w;
      w.operation = cpg_pkg::OP_START;
      w.center_x = cpg_pkg::COORD_WIDTH'(cx);
      w.center_y = cpg_pkg::COORD_WIDTH'(cy);
      w.radius = cpg_pkg::RADIUS_WIDTH'(r);
      return w;
   endfunction

   // Step words carry random centre and radius bits, which the block must ignore.
   function automatic cpg_pkg::req_type step_word();
      cpg_pkg::req_type w;
      w.operation = cpg_pkg::OP_STEP;
      w.center_x = cpg_pkg::COORD_WIDTH'($urandom);
      w.center_y = cpg_pkg::COORD_WIDTH'($urandom);
      w.radius = cpg_pkg::RADIUS_WIDTH'($urandom);
      return w;
   endfunction

   // Centres lean towards the edges of the range so that the pen wraps now and then.
   function automatic int random_coord();
      case ($urandom_range(0, 7))
         0:       return MIN_COORD;
         1:       return MAX_COORD;
         2:       return MIN_COORD + $urandom_range(0, 20);
         3:       return MAX_COORD - $urandom_range(0, 20);
         default: return int'($urandom);
      endcase
   endfunction

   // Offers one request word, waits until it is taken and records the point it causes.
   task automatic send_word(input cpg_pkg::req_type w, output cpg_pkg::rsp_type p);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      p = trace_point(w);
      expected_points.push_back(p);
      words_sent++;
      if (w.operation == cpg_pkg::OP_START)
         starts_sent++;
      if (p.last_point)
         circles_done++;
   endtask

   // Starts a circle and steps it until it closes or the step budget runs out.
   task automatic draw_circle(input int cx, input int cy, input int r, input int max_steps);
      cpg_pkg::rsp_type p;
      int               n;
      send_word(start_word(cx, cy, r), p);
      n = 0;
      while (!p.last_point && n < max_steps) begin
         send_word(step_word(), p);
         n++;
      end
   endtask

   // Steps with nothing running, and a zero radius that finishes on its start point.
   task automatic test_idle_and_zero();
      cpg_pkg::rsp_type p;
      cpg_pkg::req_type w;
      send_word(step_word(), p);
      w = '1;
      send_word(w, p);
      send_word(start_word(MIN_COORD, MAX_COORD, 0), p);
      send_word(step_word(), p);
   endtask

   // Wrapping at the edges of the coordinate range, the largest radius and a restart.
   task automatic test_wrap_and_restart();
      cpg_pkg::rsp_type p;
      draw_circle(MIN_COORD, MIN_COORD, 1, NO_LIMIT);
      send_word(step_word(), p);
      draw_circle(MAX_COORD, MAX_COORD, MAX_RADIUS, 4);
      draw_circle(MAX_COORD, MIN_COORD, 2, NO_LIMIT);
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering words.
   task automatic test_back_pressure();
      idle_on = 1'b0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      draw_circle(100, -100, SMALL_RADIUS, NO_LIMIT);
      idle_on = 1'b1;
   endtask

   // Mostly whole small circles, with aborted circles, large radii and stray steps mixed in.
   task automatic test_random_circles(input int count, input logic allow_idle);
      cpg_pkg::rsp_type p;
      int               first, pick, r;
      first = words_sent;
      while (words_sent - first < count) begin
         idle_on = allow_idle && ($urandom_range(0, 5) != 0);
         pick = $urandom_range(0, 15);
         if (pick < 10) begin
            r = $urandom_range(1, SMALL_RADIUS);
            if ($urandom_range(0, 7) == 0)
               draw_circle(random_coord(), random_coord(), r, $urandom_range(0, 4 * r));
            else
               draw_circle(random_coord(), random_coord(), r, NO_LIMIT);
         end else if (pick < 12) begin
            draw_circle(random_coord(), random_coord(), $urandom_range(0, MAX_RADIUS),
                        $urandom_range(1, 12));
         end else if (pick == 12) begin
            draw_circle(random_coord(), random_coord(), 0, 0);
         end else begin
            repeat ($urandom_range(1, 3)) send_word(step_word(), p);
         end
      end
   endtask

   // Last part of the run: no idling on either side.
   task automatic test_flat_out();
      test_random_circles(FLAT_OUT_WORDS, 1'b0);
   endtask

   function automatic void compare_field(input string name, input logic signed [31:0] want,
                                         input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Receiver stall: random bursts, or the long hold when asked.
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 13);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Each accepted response word is checked against the oldest traced point.
   always @(posedge clock) begin : response_check
      cpg_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected response word: point_x %0d point_y %0d",
                   rsp_word.point_x, rsp_word.point_y);
            fail_count++;
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            compare_field("point_x", want.point_x, rsp_word.point_x);
            compare_field("point_y", want.point_y, rsp_word.point_y);
            compare_field("pen_down", want.pen_down, rsp_word.pen_down);
            compare_field("last_point", want.last_point, rsp_word.last_point);
            compare_field("point_valid", want.point_valid, rsp_word.point_valid);
         end
      end
   end

   initial begin
      // The tracer starts from the reset state of the block: idle, pen at the origin.
      pen_x = '0;
      pen_y = '0;
      quad = '0;
      h_term = 1;
      v_term = -1;
      e_term = '0;
      circle_radius = '0;
      drawing = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_idle_and_zero();
      test_wrap_and_restart();
      test_back_pressure();
      test_random_circles(RANDOM_WORDS, 1'b1);
      test_flat_out();

      // Let the last points come out, then allow a few quiet cycles.
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d request words with %0d circle starts; %0d circles were closed.",
               words_sent, starts_sent, circles_done);
      $display("Checked %0d response words, including a long receiver hold-off.",
               points_checked);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
